/* src/amf_pkg.sv */
package amf_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int COEF_W      = 16;
  localparam int NUM_COEF    = 4;
  localparam int REG_W       = 64;
  localparam int ORDER_W     = 3;
  localparam int DELAY_W     = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int TAP_W       = 4;
  localparam int ROUND_SHIFT = 14;

  localparam logic [CFG_IDX_W-1:0] CFG_A_COEFFS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_B_COEFFS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_A_ORDER     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_B_ORDER     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_DELAY = 3'd4;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] in_sample;
    logic signed [SAMPLE_W-1:0] noise_sample;
  } in_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_sample;
    logic                       saturated;
  } out_beat_t;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_BTAP,
    OP_ATAP,
    OP_NOP,
    OP_ROUND,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    S_LOAD,
    S_BTAP,
    S_ATAP,
    S_DRAIN,
    S_ROUND,
    S_EMIT
  } step_e;

  typedef struct packed {
    op_e   op;
    logic  wait_in;
    logic  wait_out;
    logic  loop;
    step_e nxt;
  } uword_t;

  typedef struct packed {
    logic             load;
    logic             tap;
    logic             tap_a;
    logic [TAP_W-1:0] tap_idx;
    logic             round;
    logic             emit;
  } ctrl_t;

  // microcode ROM: one control word per step
  function automatic uword_t ucode(input step_e s);
    uword_t w;
    unique case (s)
      S_LOAD:  w = '{op: OP_LOAD,  wait_in: 1'b1, wait_out: 1'b0, loop: 1'b0, nxt: S_BTAP};
      S_BTAP:  w = '{op: OP_BTAP,  wait_in: 1'b0, wait_out: 1'b0, loop: 1'b1, nxt: S_ATAP};
      S_ATAP:  w = '{op: OP_ATAP,  wait_in: 1'b0, wait_out: 1'b0, loop: 1'b1, nxt: S_DRAIN};
      S_DRAIN: w = '{op: OP_NOP,   wait_in: 1'b0, wait_out: 1'b0, loop: 1'b0, nxt: S_ROUND};
      S_ROUND: w = '{op: OP_ROUND, wait_in: 1'b0, wait_out: 1'b0, loop: 1'b0, nxt: S_EMIT};
      S_EMIT:  w = '{op: OP_EMIT,  wait_in: 1'b0, wait_out: 1'b1, loop: 1'b0, nxt: S_LOAD};
      default: w = '{op: OP_NOP,   wait_in: 1'b0, wait_out: 1'b0, loop: 1'b0, nxt: S_LOAD};
    endcase
    return w;
  endfunction

endpackage

/* src/amf_seq.sv */
module amf_seq #(
  parameter int MAX_ORDER = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         out_free_i,
  input  logic [amf_pkg::ORDER_W-1:0]  a_order_i,
  input  logic [amf_pkg::ORDER_W-1:0]  b_order_i,
  output logic                         in_ready_o,
  output amf_pkg::ctrl_t               ctrl_o
);
  import amf_pkg::*;

  step_e            step_q, step_d;
  logic [TAP_W-1:0] cnt_q, cnt_d;
  uword_t           uw;
  logic [TAP_W-1:0] na, nb, lim;
  logic             go, more;

  always_comb begin
    na = (TAP_W'(a_order_i) > TAP_W'(MAX_ORDER)) ? TAP_W'(MAX_ORDER) : TAP_W'(a_order_i);
    nb = (TAP_W'(b_order_i) > TAP_W'(MAX_ORDER)) ? TAP_W'(MAX_ORDER) : TAP_W'(b_order_i);
  end

  always_comb begin
    uw   = ucode(step_q);
    lim  = (uw.op == OP_ATAP) ? na : nb;
    go   = 1'b1;
    if (uw.wait_in) begin
      go = in_valid_i;
    end
    if (uw.wait_out) begin
      go = out_free_i;
    end
    more   = uw.loop && (cnt_q < lim);
    step_d = step_q;
    cnt_d  = cnt_q;
    if (more) begin
      cnt_d = cnt_q + TAP_W'(1);
    end else if (go) begin
      step_d = uw.nxt;
      cnt_d  = '0;
    end
  end

  always_comb begin
    in_ready_o     = uw.wait_in;
    ctrl_o.load    = (uw.op == OP_LOAD) && go;
    ctrl_o.tap     = more;
    ctrl_o.tap_a   = (uw.op == OP_ATAP);
    ctrl_o.tap_idx = cnt_q;
    ctrl_o.round   = (uw.op == OP_ROUND);
    ctrl_o.emit    = (uw.op == OP_EMIT) && go;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= S_LOAD;
      cnt_q  <= '0;
    end else begin
      step_q <= step_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

/* src/amf_hist.sv */
module amf_hist #(
  parameter int HISTORY_DEPTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  amf_pkg::ctrl_t                      ctrl_i,
  input  logic signed [amf_pkg::SAMPLE_W-1:0] wdata_i,
  input  logic [amf_pkg::DELAY_W-1:0]         delay_i,
  output logic signed [amf_pkg::SAMPLE_W-1:0] rdata_o
);
  import amf_pkg::*;

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int PW = AW + 1;
  localparam int DW = (PW > DELAY_W) ? PW : DELAY_W;

  logic signed [SAMPLE_W-1:0] mem [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0]   valid_q;
  logic [AW-1:0]              pos_q, pos_d;
  logic [AW-1:0]              addr_q, addr_d;
  logic signed [SAMPLE_W-1:0] rd_q;
  logic                       rv_q;
  logic [DW-1:0]              dly, doff_full;
  logic [AW-1:0]              doff;
  logic [PW-1:0]              start;

  always_comb begin
    dly       = DW'(delay_i);
    doff_full = (dly >= DW'(HISTORY_DEPTH)) ? dly - DW'(HISTORY_DEPTH) : dly;
    doff      = doff_full[AW-1:0];
    start     = PW'(pos_q) + PW'(HISTORY_DEPTH) - PW'(doff);
    if (start >= PW'(HISTORY_DEPTH)) begin
      start = start - PW'(HISTORY_DEPTH);
    end
    pos_d  = pos_q;
    addr_d = addr_q;
    if (ctrl_i.load) begin
      pos_d  = (pos_q == AW'(HISTORY_DEPTH - 1)) ? '0 : pos_q + AW'(1);
      addr_d = start[AW-1:0];
    end else if (ctrl_i.tap && !ctrl_i.tap_a) begin
      addr_d = (addr_q == '0) ? AW'(HISTORY_DEPTH - 1) : addr_q - AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      addr_q  <= '0;
      valid_q <= '0;
      rv_q    <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      addr_q <= addr_d;
      if (ctrl_i.load) begin
        valid_q[pos_q] <= 1'b1;
      end
      rv_q <= valid_q[addr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      mem[pos_q] <= wdata_i;
    end
    rd_q <= mem[addr_q];
  end

  // never-written slots read as zero
  assign rdata_o = rv_q ? rd_q : '0;

endmodule

/* src/amf_mac.sv */
module amf_mac #(
  parameter int MAX_ORDER = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  amf_pkg::ctrl_t                      ctrl_i,
  input  logic [amf_pkg::REG_W-1:0]           a_coeffs_i,
  input  logic [amf_pkg::REG_W-1:0]           b_coeffs_i,
  input  logic signed [amf_pkg::SAMPLE_W-1:0] noise_i,
  input  logic signed [amf_pkg::SAMPLE_W-1:0] hist_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output amf_pkg::out_beat_t                  out_data_o,
  output logic                                out_free_o
);
  import amf_pkg::*;

  localparam int SW    = SAMPLE_W;
  localparam int PRW   = SW + COEF_W;
  localparam int ACC_W = PRW + $clog2(2 * MAX_ORDER) + 1;
  localparam int YF_W  = ACC_W - ROUND_SHIFT;
  localparam int YI_W  = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam logic signed [ACC_W-1:0] RBIAS = ACC_W'(1) << (ROUND_SHIFT - 1);
  localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

  logic signed [SW-1:0]     yh_q [MAX_ORDER];
  logic signed [SW-1:0]     noise_q, y_q, a_op_s1_q;
  logic signed [COEF_W-1:0] coef_s1_q, coef;
  logic                     v1_q, sub1_q, v2_q, sub2_q;
  logic signed [PRW-1:0]    prod_q;
  logic signed [ACC_W-1:0]  acc_q, rsum, prod_ext;
  logic signed [YF_W-1:0]   yf;
  logic signed [SW-1:0]     ysat, osat, opnd;
  logic [SW:0]              osum;
  logic                     yovf, oovf, clip_q, out_valid_q;
  logic [REG_W-1:0]         pk;
  out_beat_t                out_q;

  always_comb begin
    pk   = ctrl_i.tap_a ? a_coeffs_i : b_coeffs_i;
    coef = (ctrl_i.tap_idx < TAP_W'(NUM_COEF)) ?
           pk[{ctrl_i.tap_idx[1:0], 4'b0000} +: COEF_W] : '0;
    opnd = sub1_q ? a_op_s1_q : hist_i;
    prod_ext = {{(ACC_W-PRW){prod_q[PRW-1]}}, prod_q};
  end

  always_comb begin
    rsum = acc_q + RBIAS;
    yf   = rsum[ACC_W-1:ROUND_SHIFT];
    yovf = !((&yf[YF_W-1:SW-1]) || !(|yf[YF_W-1:SW-1]));
    ysat = yovf ? (yf[YF_W-1] ? S_MIN : S_MAX) : yf[SW-1:0];
    osum = {y_q[SW-1], y_q} + {noise_q[SW-1], noise_q};
    oovf = osum[SW] ^ osum[SW-1];
    osat = oovf ? (osum[SW] ? S_MIN : S_MAX) : osum[SW-1:0];
  end

  assign out_free_o = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MAX_ORDER; i++) begin
        yh_q[i] <= '0;
      end
    end else begin
      v1_q <= ctrl_i.tap;
      v2_q <= v1_q;
      if (ctrl_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (ctrl_i.round) begin
        for (int i = MAX_ORDER - 1; i > 0; i--) begin
          yh_q[i] <= yh_q[i-1];
        end
        yh_q[0] <= ysat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      noise_q <= noise_i;
    end
    if (ctrl_i.tap) begin
      coef_s1_q <= coef;
      sub1_q    <= ctrl_i.tap_a;
      a_op_s1_q <= yh_q[ctrl_i.tap_idx[YI_W-1:0]];
    end
    if (v1_q) begin
      prod_q <= coef_s1_q * opnd;
      sub2_q <= sub1_q;
    end
    if (ctrl_i.load) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= sub2_q ? acc_q - prod_ext : acc_q + prod_ext;
    end
    if (ctrl_i.round) begin
      y_q    <= ysat;
      clip_q <= yovf;
    end
    if (ctrl_i.emit) begin
      out_q.out_sample <= osat;
      out_q.saturated  <= clip_q | oovf;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* src/arx_model_filter_unit.sv */
// ARX model filter: y = sum b_i*u[k-d-i] - sum a_j*y[k-j], output y + noise.
// Input channel in_valid_i/in_ready_o carries one beat: plant sample and noise
// sample, both signed Q4.12. Output channel out_valid_o/out_ready_i returns one
// beat per input: saturated sample and a clip flag.
// Configuration goes through cfg_we_i/cfg_idx_i/cfg_data_i, which the user must
// write only while idle; the block does not enforce this. Indices: 0 a_coeffs,
// 1 b_coeffs, 2 a_order, 3 b_order, 4 input_delay. A microcode sequencer steps
// one shared multiply-accumulate unit through the taps in turn, with load,
// loop-exit, drain, round and emit steps around them. The tap counts nb, na are
// the orders clipped to MAX_ORDER. A new beat is taken only after the previous
// one has passed the emit step, and in_ready_o is high only in the load step.
// The output register holds a result until taken; the next beat
// is accepted and computed meanwhile, and the sequencer waits in its emit step
// only if the previous result is still unclaimed.
// Reset clears configuration, histories and the write position, so outputs
// equal the noise until configured. Stored history slots start as zero through
// per-slot valid bits, no clearing pass is needed.
module arx_model_filter_unit #(
  parameter int MAX_ORDER     = 4,
  parameter int HISTORY_DEPTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  amf_pkg::in_beat_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output amf_pkg::out_beat_t                out_data_o,
  input  logic                              cfg_we_i,
  input  logic [amf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [amf_pkg::REG_W-1:0]         cfg_data_i
);
  import amf_pkg::*;

  logic [REG_W-1:0]    a_coeffs_q, b_coeffs_q;
  logic [ORDER_W-1:0]  a_order_q, b_order_q;
  logic [DELAY_W-1:0]  delay_q;
  ctrl_t               ctrl;
  logic                out_free;
  logic signed [SAMPLE_W-1:0] hist_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_coeffs_q <= '0;
      b_coeffs_q <= '0;
      a_order_q  <= '0;
      b_order_q  <= '0;
      delay_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_A_COEFFS:    a_coeffs_q <= cfg_data_i;
        CFG_B_COEFFS:    b_coeffs_q <= cfg_data_i;
        CFG_A_ORDER:     a_order_q  <= cfg_data_i[ORDER_W-1:0];
        CFG_B_ORDER:     b_order_q  <= cfg_data_i[ORDER_W-1:0];
        CFG_INPUT_DELAY: delay_q    <= cfg_data_i[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  amf_seq #(
    .MAX_ORDER(MAX_ORDER)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .a_order_i  (a_order_q),
    .b_order_i  (b_order_q),
    .in_ready_o (in_ready_o),
    .ctrl_o     (ctrl)
  );

  amf_hist #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_hist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .wdata_i (in_data_i.in_sample),
    .delay_i (delay_q),
    .rdata_o (hist_data)
  );

  amf_mac #(
    .MAX_ORDER(MAX_ORDER)
  ) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .a_coeffs_i  (a_coeffs_q),
    .b_coeffs_i  (b_coeffs_q),
    .noise_i     (in_data_i.noise_sample),
    .hist_i      (hist_data),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_free_o  (out_free)
  );

endmodule
